// ===== rtl/hce_pkg.sv =====
// Shared types and constants for the chunked transfer encoder.
// Holds chunk sizing, action codes, output characters and the command/status structs.
// Depends on nothing; every other file but hce_ram refers to it by scoped names.
`default_nettype none

package hce_pkg;

  // Chunk buffer sizing.
  localparam int CHUNK_CAPACITY = 32;
  localparam int FILL_W         = 6;
  localparam int ADDR_W         = (CHUNK_CAPACITY > 1) ? $clog2(CHUNK_CAPACITY) : 1;
  localparam int BYTE_W         = 8;
  localparam int ACTION_W       = 2;

  // Action codes carried by an input item.
  localparam logic [ACTION_W-1:0] ACT_DATA   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

  // Line ending characters.
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // Terminator sent by finish: "0" CR LF CR LF.
  localparam int TERM_LEN = 5;
  localparam int TCNT_W   = 3;
  localparam logic [BYTE_W-1:0] TERM_BYTES [TERM_LEN] = '{8'h30, 8'h0D, 8'h0A, 8'h0D, 8'h0A};

  // Uppercase hex digit characters.
  localparam logic [BYTE_W-1:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Source of the next output byte.
  typedef enum logic [2:0] {
    SRC_CR,
    SRC_LF,
    SRC_HEX_HI,
    SRC_HEX_LO,
    SRC_RAM,
    SRC_TERM
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_item;   // write the item byte at the fill count and count it
    logic save_item;    // capture the item and restart the terminator count
    logic emit;         // load the output register
    src_t sel;          // what the output register loads
    logic last;         // final byte of this item
    logic rd_first;     // read the first stored byte
    logic rd_next;      // read the byte after the current one
    logic term_step;    // advance through the terminator
    logic clear_fill;   // empty the chunk buffer
    logic store_saved;  // store the held payload byte as the first of a new chunk
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_load;      // output register can take a byte this cycle
    logic fill_full;
    logic fill_empty;
    logic hex_hi_nz;     // chunk length needs two hex digits
    logic data_last;     // current stored byte is the final one
    logic term_last;     // current terminator byte is the final one
    logic saved_data;    // held item is a payload byte
    logic saved_finish;  // held item is a finish
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hce_if.sv =====
// Handshake channel interfaces for the chunked transfer encoder.
// hce_in_if carries input items, hce_out_if carries output bytes.
// Depends on hce_pkg for field widths.
`default_nettype none

interface hce_in_if;
  logic                               valid;
  logic                               ready;
  logic [hce_pkg::ACTION_W-1:0]       action;
  logic [hce_pkg::BYTE_W-1:0]         data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface hce_out_if;
  logic                       valid;
  logic                       ready;
  logic [hce_pkg::BYTE_W-1:0] out_byte;
  logic                       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hce_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the chunk buffer. No dependencies.
`default_nettype none

module hce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hce_ctrl.sv =====
// Controller state machine of the chunked transfer encoder.
// Decides per input item what to send and steps the datapath through a chunk.
// Depends on hce_pkg for action codes and the command/status structs.
`default_nettype none

module hce_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [hce_pkg::ACTION_W-1:0]  item_action,
  input  hce_pkg::dp_stat_t             stat,
  output hce_pkg::dp_cmd_t              cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HEX_HI = 9'b000000010,
    S_HEX_LO = 9'b000000100,
    S_CR1    = 9'b000001000,
    S_LF1    = 9'b000010000,
    S_DATA   = 9'b000100000,
    S_CR2    = 9'b001000000,
    S_LF2    = 9'b010000000,
    S_TERM   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t hex_start;
  logic   accept;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign hex_start  = stat.hex_hi_nz ? S_HEX_HI : S_HEX_LO;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item_action)
            hce_pkg::ACT_DATA: begin
              if (stat.fill_full) begin
                cmd.save_item = 1'b1;
                state_next    = hex_start;
              end else begin
                cmd.store_item = 1'b1;
              end
            end
            hce_pkg::ACT_FLUSH: begin
              if (!stat.fill_empty) begin
                cmd.save_item = 1'b1;
                state_next    = hex_start;
              end
            end
            hce_pkg::ACT_FINISH: begin
              cmd.save_item = 1'b1;
              state_next    = stat.fill_empty ? S_TERM : hex_start;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_HEX_HI: begin
        if (stat.out_load) begin
          cmd.emit   = 1'b1;
          cmd.sel    = hce_pkg::SRC_HEX_HI;
          state_next = S_HEX_LO;
        end
      end
      S_HEX_LO: begin
        if (stat.out_load) begin
          cmd.emit   = 1'b1;
          cmd.sel    = hce_pkg::SRC_HEX_LO;
          state_next = S_CR1;
        end
      end
      S_CR1: begin
        if (stat.out_load) begin
          cmd.emit   = 1'b1;
          cmd.sel    = hce_pkg::SRC_CR;
          state_next = S_LF1;
        end
      end
      S_LF1: begin
        // The first stored byte is fetched while LF goes out.
        if (stat.out_load) begin
          cmd.emit     = 1'b1;
          cmd.sel      = hce_pkg::SRC_LF;
          cmd.rd_first = 1'b1;
          state_next   = S_DATA;
        end
      end
      S_DATA: begin
        if (stat.out_load) begin
          cmd.emit = 1'b1;
          cmd.sel  = hce_pkg::SRC_RAM;
          if (stat.data_last) begin
            state_next = S_CR2;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_CR2: begin
        if (stat.out_load) begin
          cmd.emit   = 1'b1;
          cmd.sel    = hce_pkg::SRC_CR;
          state_next = S_LF2;
        end
      end
      S_LF2: begin
        // End of chunk: a held payload byte opens the next chunk.
        if (stat.out_load) begin
          cmd.emit = 1'b1;
          cmd.sel  = hce_pkg::SRC_LF;
          cmd.last = !stat.saved_finish;
          if (stat.saved_data) begin
            cmd.store_saved = 1'b1;
          end else begin
            cmd.clear_fill = 1'b1;
          end
          state_next = stat.saved_finish ? S_TERM : S_IDLE;
        end
      end
      S_TERM: begin
        if (stat.out_load) begin
          cmd.emit      = 1'b1;
          cmd.sel       = hce_pkg::SRC_TERM;
          cmd.last      = stat.term_last;
          cmd.term_step = 1'b1;
          if (stat.term_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hce_dp.sv =====
// Datapath of the chunked transfer encoder: chunk buffer, fill count,
// read index, terminator count and the output register.
// Depends on hce_pkg and hce_ram.
`default_nettype none

module hce_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hce_pkg::BYTE_W-1:0]   item_data,
  input  logic [hce_pkg::ACTION_W-1:0] item_action,
  input  hce_pkg::dp_cmd_t             cmd,
  output hce_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hce_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last
);

  logic [hce_pkg::FILL_W-1:0]   fill;
  logic [hce_pkg::FILL_W-1:0]   idx;
  logic [hce_pkg::FILL_W-1:0]   idx_inc;
  logic [hce_pkg::TCNT_W-1:0]   tcnt;
  logic [hce_pkg::ACTION_W-1:0] saved_action;
  logic [hce_pkg::BYTE_W-1:0]   saved_byte;

  logic                         ram_we;
  logic [hce_pkg::ADDR_W-1:0]   ram_waddr;
  logic [hce_pkg::BYTE_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [hce_pkg::ADDR_W-1:0]   ram_raddr;
  logic [hce_pkg::BYTE_W-1:0]   ram_rdata;
  logic [hce_pkg::BYTE_W-1:0]   byte_mux;

  assign idx_inc = idx + 1'b1;

  // Chunk buffer write and read port control.
  assign ram_we    = cmd.store_item || cmd.store_saved;
  assign ram_waddr = cmd.store_saved ? '0 : fill[hce_pkg::ADDR_W-1:0];
  assign ram_wdata = cmd.store_saved ? saved_byte : item_data;
  assign ram_re    = cmd.rd_first || cmd.rd_next;
  assign ram_raddr = cmd.rd_first ? '0 : idx_inc[hce_pkg::ADDR_W-1:0];

  hce_ram #(
    .WIDTH (hce_pkg::BYTE_W),
    .DEPTH (hce_pkg::CHUNK_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.store_item) begin
      fill <= fill + 1'b1;
    end else if (cmd.store_saved) begin
      fill <= hce_pkg::FILL_W'(1);
    end else if (cmd.clear_fill) begin
      fill <= '0;
    end
  end

  // Read index and terminator count.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      tcnt <= '0;
    end else begin
      if (cmd.rd_first) begin
        idx <= '0;
      end else if (cmd.rd_next) begin
        idx <= idx_inc;
      end
      if (cmd.save_item) begin
        tcnt <= '0;
      end else if (cmd.term_step) begin
        tcnt <= tcnt + 1'b1;
      end
    end
  end

  // Held item while a chunk goes out.
  always_ff @(posedge clk) begin
    if (cmd.save_item) begin
      saved_action <= item_action;
      saved_byte   <= item_data;
    end
  end

  // Output byte selection.
  always_comb begin
    case (cmd.sel)
      hce_pkg::SRC_CR:     byte_mux = hce_pkg::CHAR_CR;
      hce_pkg::SRC_LF:     byte_mux = hce_pkg::CHAR_LF;
      hce_pkg::SRC_HEX_HI: byte_mux = hce_pkg::HEX_DIGITS[{2'b00, fill[hce_pkg::FILL_W-1:4]}];
      hce_pkg::SRC_HEX_LO: byte_mux = hce_pkg::HEX_DIGITS[fill[3:0]];
      hce_pkg::SRC_RAM:    byte_mux = ram_rdata;
      hce_pkg::SRC_TERM:   byte_mux = hce_pkg::TERM_BYTES[tcnt];
      default:             byte_mux = hce_pkg::CHAR_LF;
    endcase
  end

  // Output register: takes a new byte when empty or when the current one transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= byte_mux;
      out_last <= cmd.last;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.out_load     = !out_valid || out_ready;
    stat.fill_full    = (fill == hce_pkg::FILL_W'(hce_pkg::CHUNK_CAPACITY));
    stat.fill_empty   = (fill == '0);
    stat.hex_hi_nz    = (fill[hce_pkg::FILL_W-1:4] != '0);
    stat.data_last    = (idx_inc == fill);
    stat.term_last    = (tcnt == hce_pkg::TCNT_W'(hce_pkg::TERM_LEN - 1));
    stat.saved_data   = (saved_action == hce_pkg::ACT_DATA);
    stat.saved_finish = (saved_action == hce_pkg::ACT_FINISH);
  end

endmodule

`default_nettype wire

// ===== rtl/http_chunked_encoder.sv =====
// Top level of the chunked transfer encoder: controller plus datapath.
// Depends on hce_pkg, hce_if, hce_ctrl, hce_dp and hce_ram.
//
// Payload bytes are collected in a 32-byte chunk buffer and sent out as
// chunks: the length in uppercase hex, CR LF, the bytes, CR LF. Flush sends
// a pending chunk, finish sends it and then "0" CR LF CR LF; action code 3
// is ignored. A payload byte into a buffer that is not full is taken every
// cycle while no chunk is going out and produces nothing. An item that
// sends a chunk holds the input until its final byte is loaded (the length
// takes one or two hex digits), and finish adds the terminator; the output
// register sends one byte per cycle while the output side is ready, and the
// next item is taken in the cycle after the final byte is loaded. The RAM
// buffer has one write and one registered read port, read ahead by one byte.
`default_nettype none

module http_chunked_encoder (
  input  logic       clk,
  input  logic       rst,
  hce_in_if.sink     item,
  hce_out_if.source  result
);

  hce_pkg::dp_cmd_t  cmd;
  hce_pkg::dp_stat_t stat;
  logic              item_ready;

  assign item.ready = item_ready;

  hce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_ready  (item_ready),
    .item_action (item.action),
    .stat        (stat),
    .cmd         (cmd)
  );

  hce_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .item_data   (item.data_byte),
    .item_action (item.action),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_byte    (result.out_byte),
    .out_last    (result.last)
  );

endmodule

`default_nettype wire

// ===== rtl/hce_checker.sv =====
// Port-level checks for the chunked transfer encoder, bound to its top level.
// Depends on hce_pkg for action codes and characters.
`default_nettype none

module hce_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic [hce_pkg::ACTION_W-1:0] item_action,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [hce_pkg::BYTE_W-1:0]   result_out_byte,
  input logic                         result_last
);

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_out_byte) && $stable(result_last))
    else $error("output byte changed while stalled");

  // Every item's final byte is a line feed.
  a_last_lf: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_last |-> result_out_byte == hce_pkg::CHAR_LF)
    else $error("final byte of an item is not LF");

  // While an item's bytes are still going out, no new item is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_last |-> !item_ready)
    else $error("input ready during a chunk");

  // Finish always produces output, so the input closes right after it.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_action == hce_pkg::ACT_FINISH |=> !item_ready)
    else $error("input still ready after finish");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("output valid after reset");

endmodule

bind http_chunked_encoder hce_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .item_action     (item.action),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_out_byte (result.out_byte),
  .result_last     (result.last)
);

`default_nettype wire

// ===== tb/tb_http_chunked_encoder.sv =====
// Self-checking testbench for http_chunked_encoder: a directed table, then random chunk traffic.
// Expected output bytes come from a behavioral encoder kept inside this file, or from a directed row's typed bytes.
// Depends on hce_pkg, hce_if and the encoder RTL.
`default_nettype none

module tb_http_chunked_encoder;

  // The fourth action code has no meaning and must be ignored by the block.
  localparam logic [hce_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Characters that make up the chunk framing.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam int RESET_CYCLES = 6;
  localparam int PHASE_ITEMS  = 56;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_ROWS     = 25;

  // One output byte as it should appear on the result channel.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } out_beat_t;

  // A directed row: a typed expectation applies when typed_n is not negative.
  // Typed bytes are right-aligned, first byte in the most significant position.
  typedef struct packed {
    logic [hce_pkg::ACTION_W-1:0] act;
    logic [7:0]                   din;
    logic [7:0]                   reps;
    logic signed [7:0]            typed_n;
    logic [127:0]                 typed;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{hce_pkg::ACT_FLUSH,  8'h00, 8'd1,  8'sd0,  128'h0},
    '{hce_pkg::ACT_FINISH, 8'h00, 8'd1,  8'sd5,  128'h30_0D_0A_0D_0A},
    '{ACT_UNUSED,          8'hFF, 8'd1,  8'sd0,  128'h0},
    '{hce_pkg::ACT_DATA,   8'h00, 8'd1,  8'sd0,  128'h0},
    '{ACT_UNUSED,          8'h55, 8'd1,  8'sd0,  128'h0},
    '{hce_pkg::ACT_FLUSH,  8'hFF, 8'd1,  8'sd6,  128'h31_0D_0A_00_0D_0A},
    '{hce_pkg::ACT_DATA,   8'hFF, 8'd1,  8'sd0,  128'h0},
    '{hce_pkg::ACT_FINISH, 8'hAA, 8'd1,  8'sd11, 128'h31_0D_0A_FF_0D_0A_30_0D_0A_0D_0A},
    '{hce_pkg::ACT_DATA,   8'h01, 8'd32, -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'h7E, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_FINISH, 8'h00, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'h80, 8'd32, -8'sd1, 128'h0},
    '{hce_pkg::ACT_FINISH, 8'h00, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'h10, 8'd16, -8'sd1, 128'h0},
    '{hce_pkg::ACT_FLUSH,  8'h00, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'h40, 8'd15, -8'sd1, 128'h0},
    '{hce_pkg::ACT_FLUSH,  8'h00, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'hC3, 8'd10, -8'sd1, 128'h0},
    '{hce_pkg::ACT_FLUSH,  8'h00, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'hF0, 8'd31, -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'h3C, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_DATA,   8'h0F, 8'd1,  -8'sd1, 128'h0},
    '{ACT_UNUSED,          8'h00, 8'd1,  8'sd0,  128'h0},
    '{hce_pkg::ACT_FLUSH,  8'h00, 8'd1,  -8'sd1, 128'h0},
    '{hce_pkg::ACT_FLUSH,  8'h00, 8'd1,  8'sd0,  128'h0}
  };

  logic clk = 1'b0;
  logic rst;

  hce_in_if  item_ch ();
  hce_out_if res_ch ();

  http_chunked_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (res_ch.source)
  );

  always #1 clk = ~clk;

  // Typed expectation that travels with the item currently offered.
  int           cur_typed_n;
  logic [127:0] cur_typed;

  int idle_pct;
  int stall_pct;
  int err_count;
  int cycle_count;
  int items_taken;
  int bytes_checked;
  int max_burst;

  // Behavioral encoder state and its output for one item.
  logic [7:0]  chunk_mem [hce_pkg::CHUNK_CAPACITY];
  int unsigned chunk_fill;
  out_beat_t   model_out[$];

  // Output bytes that the block still owes, oldest first.
  out_beat_t pending_stream[$];

  function automatic logic [7:0] hex_char(input int unsigned nib);
    return (nib < 10) ? 8'(CH_ZERO + nib) : 8'(CH_A + nib - 10);
  endfunction

  function automatic void add_beat(input logic [7:0] b);
    out_beat_t beat;
    beat.byte_val = b;
    beat.last     = 1'b0;
    model_out.push_back(beat);
  endfunction

  // Send the buffered chunk: hex length, CR LF, payload, CR LF.
  function automatic void send_chunk();
    bit          started;
    int          sh;
    int unsigned nib;
    if (chunk_fill == 0) return;
    started = 1'b0;
    for (sh = 28; sh >= 0; sh -= 4) begin
      nib = (chunk_fill >> sh) & 4'hF;
      if (nib != 0 || started) begin
        started = 1'b1;
        add_beat(hex_char(nib));
      end
    end
    add_beat(CH_CR);
    add_beat(CH_LF);
    for (int i = 0; i < chunk_fill; i++) add_beat(chunk_mem[i]);
    add_beat(CH_CR);
    add_beat(CH_LF);
    chunk_fill = 0;
  endfunction

  // Work out the bytes that one accepted item produces.
  function automatic void encode_item(input logic [hce_pkg::ACTION_W-1:0] act,
                                      input logic [7:0] din);
    model_out.delete();
    case (act)
      hce_pkg::ACT_DATA: begin
        if (chunk_fill >= hce_pkg::CHUNK_CAPACITY) send_chunk();
        chunk_mem[chunk_fill] = din;
        chunk_fill++;
      end
      hce_pkg::ACT_FLUSH: begin
        send_chunk();
      end
      hce_pkg::ACT_FINISH: begin
        send_chunk();
        add_beat(CH_ZERO);
        add_beat(CH_CR);
        add_beat(CH_LF);
        add_beat(CH_CR);
        add_beat(CH_LF);
      end
      default: ;
    endcase
    if (model_out.size() > 0) model_out[model_out.size() - 1].last = 1'b1;
  endfunction

  // Predict on every input transfer, then check every output transfer.
  always @(posedge clk) begin
    out_beat_t beat;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        encode_item(item_ch.action, item_ch.data_byte);
        if (cur_typed_n >= 0) begin
          for (int i = 0; i < cur_typed_n; i++) begin
            beat.byte_val = cur_typed[8 * (cur_typed_n - 1 - i) +: 8];
            beat.last     = (i == cur_typed_n - 1);
            pending_stream.push_back(beat);
          end
        end else begin
          foreach (model_out[i]) pending_stream.push_back(model_out[i]);
        end
        if (model_out.size() > max_burst) max_burst = model_out.size();
        if (item_ch.action != ACT_UNUSED) items_taken++;
      end
      if (res_ch.valid && res_ch.ready) begin
        bytes_checked++;
        if (pending_stream.size() == 0) begin
          $error("unexpected output byte %h with last %b", res_ch.out_byte, res_ch.last);
          err_count++;
        end else begin
          beat = pending_stream.pop_front();
          if (res_ch.out_byte !== beat.byte_val) begin
            $error("out_byte: expected %h, actual %h", beat.byte_val, res_ch.out_byte);
            err_count++;
          end
          if (res_ch.last !== beat.last) begin
            $error("last: expected %b, actual %b", beat.last, res_ch.last);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver side: random stalls at the current rate.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("http_chunked_encoder regression: fail");
      $finish;
    end
  end

  // Offer one item, with random idle cycles first; returns after its transfer.
  task automatic send_item(input logic [hce_pkg::ACTION_W-1:0] act, input logic [7:0] din,
                           input int typed_n, input logic [127:0] typed);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= act;
    item_ch.data_byte <= din;
    cur_typed_n       <= typed_n;
    cur_typed         <= typed;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  // A run of payload bytes, sometimes full-size or longer, closed by a flush, a finish, a stray item or nothing.
  task automatic send_chunk_sequence(inout int sent);
    int                           burst;
    int                           pick;
    logic [hce_pkg::ACTION_W-1:0] stray_act;
    pick = $urandom_range(0, 9);
    if (pick < 6)       burst = $urandom_range(1, hce_pkg::CHUNK_CAPACITY - 1);
    else if (pick < 8)  burst = hce_pkg::CHUNK_CAPACITY;
    else if (pick == 8) burst = $urandom_range(hce_pkg::CHUNK_CAPACITY + 1,
                                               2 * hce_pkg::CHUNK_CAPACITY + 6);
    else                burst = 0;
    for (int k = 0; k < burst; k++) begin
      if ($urandom_range(0, 19) == 0) send_item(ACT_UNUSED, 8'($urandom), -1, '0);
      send_item(hce_pkg::ACT_DATA, 8'($urandom_range(0, 255)), -1, '0);
      sent++;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_item(hce_pkg::ACT_FLUSH, 8'($urandom), -1, '0);
      sent++;
    end else if (pick < 8) begin
      send_item(hce_pkg::ACT_FINISH, 8'($urandom), -1, '0);
      sent++;
    end else if (pick == 8) begin
      // Stray item of any kind, including the ignored code.
      pick      = $urandom_range(0, 3);
      stray_act = pick[hce_pkg::ACTION_W-1:0];
      send_item(stray_act, 8'($urandom), -1, '0);
      if (stray_act != ACT_UNUSED) sent++;
    end
  endtask

  initial begin
    int sent;
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.action    = hce_pkg::ACT_DATA;
    item_ch.data_byte = 8'h00;
    res_ch.ready      = 1'b0;
    cur_typed_n       = -1;
    cur_typed         = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    err_count         = 0;
    cycle_count       = 0;
    items_taken       = 0;
    bytes_checked     = 0;
    max_burst         = 0;
    chunk_fill        = 0;
    foreach (chunk_mem[i]) chunk_mem[i] = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows; repeated rows step the payload byte by one each time.
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
        send_item(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].din + 8'(k),
                  DIRECTED_ROWS[r].typed_n, DIRECTED_ROWS[r].typed);
      end
    end

    // Random traffic in four phases of sender idling and receiver stalls.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) send_chunk_sequence(sent);
    end
    item_ch.valid <= 1'b0;

    while (pending_stream.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items and %0d output bytes; largest burst from one item: %0d bytes.",
             items_taken, bytes_checked, max_burst);
    $display("Ran four phases of sender idling and receiver stalls after the directed rows.");
    if (err_count == 0) begin
      $display("http_chunked_encoder regression: pass");
    end else begin
      $display("http_chunked_encoder regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
